// ===== hdl/lsf_pkg.sv =====
// lsf_pkg: shared types and constants for the line substring filter.
// No dependencies; imported by every module of the block.
package lsf_pkg;

  // Default sizes of the line store and the pattern
  localparam int LINE_MAX_DEFAULT    = 63;
  localparam int PATTERN_MAX_DEFAULT = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int PAT_LEN_W   = 5;

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

  localparam logic [7:0] NEWLINE   = 8'd10;
  localparam logic [7:0] ZERO_BYTE = 8'd0;

  // Input and output items
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_line;
  } out_item_t;

  // Controller states
  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } lsf_state_t;

  // Control for the line byte cells
  typedef struct packed {
    logic write;
    logic shift;
  } byte_ctrl_t;

  // Control for the match cells
  typedef struct packed {
    logic clear;
    logic advance;
  } match_ctrl_t;

endpackage

// ===== hdl/lsf_byte_cell.sv =====
// lsf_byte_cell: one byte of the line store.
// Depends on lsf_pkg. Loaded by index while collecting, shifts toward cell 0 while emitting.
module lsf_byte_cell (
  input  logic               clk,
  input  lsf_pkg::byte_ctrl_t ctrl,
  input  logic [7:0]         wdata,
  input  logic [7:0]         from_next,
  output logic [7:0]         data
);
  import lsf_pkg::*;

  // Store a new byte or take the neighbor's byte
  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      data <= wdata;
    end else if (ctrl.shift) begin
      data <= from_next;
    end
  end

endmodule

// ===== hdl/lsf_match_cell.sv =====
// lsf_match_cell: one pattern position of the incremental string matcher.
// Depends on lsf_pkg. Holds whether the text so far ends in the pattern prefix up to here.
module lsf_match_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  lsf_pkg::match_ctrl_t ctrl,
  input  logic [7:0]           line_byte,
  input  logic [7:0]           pat_byte,
  input  logic                 prev_matched,
  output logic                 hit,
  output logic                 matched
);
  import lsf_pkg::*;

  // Prefix up to the previous position matched and this byte agrees
  assign hit = prev_matched && (line_byte == pat_byte);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      matched <= 1'b0;
    end else if (ctrl.advance) begin
      matched <= hit;
    end
  end

endmodule

// ===== hdl/line_substring_filter_unit.sv =====
// line_substring_filter_unit: top level of the fixed-string line filter.
// Depends on lsf_pkg, lsf_byte_cell and lsf_match_cell.
//
// Bytes are taken one per cycle while a line is collected; a row of LINE_MAX
// byte cells holds the line and a row of PATTERN_MAX match cells tracks the
// search as each byte arrives, so the match is known when the line closes.
// A newline, or end of input on a nonempty line, closes the line. A matching
// line is then shifted out of the byte row toward cell 0, one byte per cycle
// that the output side accepts, followed by a newline with last_of_line set;
// input is held off until that newline is emitted, the bytes sent being the
// line up to its first zero byte. Other lines never hold off input. The user
// must write the config port only while idle; the block does not enforce it.
module line_substring_filter_unit #(
  parameter int LINE_MAX    = lsf_pkg::LINE_MAX_DEFAULT,
  parameter int PATTERN_MAX = lsf_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lsf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lsf_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lsf_pkg::out_item_t              out_item
);
  import lsf_pkg::*;

  localparam int LEN_W = $clog2(LINE_MAX + 1);
  localparam int PL_W  = $clog2(PATTERN_MAX + 1);

  // Configuration registers
  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [PAT_LEN_W-1:0]  pattern_length;

  // Control state
  lsf_state_t       state;
  lsf_state_t       state_next;
  logic [LEN_W-1:0] line_len;
  logic [LEN_W-1:0] text_len;
  logic [LEN_W-1:0] remain;
  logic             zero_seen;
  logic             found;

  // Decode and control
  logic [2*CFG_DATA_W-1:0] pattern_all;
  logic [PAT_LEN_W-1:0]    plen_clamped;
  logic [PL_W-1:0]         plen_eff;
  logic                    accept;
  logic                    is_end;
  logic                    is_newline;
  logic                    close_line;
  logic                    store;
  logic                    search;
  logic                    line_matched;
  logic                    found_hit;
  logic                    out_free;
  logic                    emit_byte;
  logic                    emit_last;
  byte_ctrl_t              byte_ctrl [LINE_MAX];
  match_ctrl_t             match_ctrl;

  // Cell rows
  logic [7:0]       cell_data [LINE_MAX];
  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX-1:0] matched;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_LOW:    pattern_low    <= cfg_data;
        CFG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[PAT_LEN_W-1:0];
        default:            ;
      endcase
    end
  end

  // Effective pattern length: clamp, then cut at the first zero byte
  assign pattern_all  = {pattern_high, pattern_low};
  assign plen_clamped = (pattern_length > PAT_LEN_W'(PATTERN_MAX)) ?
                        PAT_LEN_W'(PATTERN_MAX) : pattern_length;

  always_comb begin
    plen_eff = plen_clamped[PL_W-1:0];
    for (int k = PATTERN_MAX - 1; k >= 0; k--) begin
      if ((PAT_LEN_W'(k) < plen_clamped) && (pattern_all[8*k +: 8] == ZERO_BYTE)) begin
        plen_eff = PL_W'(k);
      end
    end
  end

  // Input decode
  assign in_ready   = (state == ST_COLLECT);
  assign accept     = in_valid && in_ready;
  assign is_end     = in_item.end_of_input;
  assign is_newline = !is_end && (in_item.in_byte == NEWLINE);
  assign close_line = accept && (is_newline || (is_end && (line_len != '0)));
  assign store      = accept && !is_end && !is_newline && (line_len < LEN_W'(LINE_MAX));
  assign search     = store && !zero_seen && (in_item.in_byte != ZERO_BYTE);

  // Hit at the last pattern position in use
  always_comb begin
    found_hit = 1'b0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (PL_W'(k + 1) == plen_eff) begin
        found_hit = hit[k];
      end
    end
  end

  assign line_matched = (plen_eff == '0) || found;
  assign out_free     = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (close_line && line_matched) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && (remain == '0)) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    emit_byte = 1'b0;
    emit_last = 1'b0;
    case (state)
      ST_COLLECT: ;
      ST_EMIT: begin
        emit_byte = out_free && (remain != '0);
        emit_last = out_free && (remain == '0);
      end
      default: ;
    endcase
  end

  assign match_ctrl.clear   = close_line;
  assign match_ctrl.advance = search;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // Line bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      line_len  <= '0;
      text_len  <= '0;
      zero_seen <= 1'b0;
      found     <= 1'b0;
      remain    <= '0;
    end else begin
      if (close_line) begin
        line_len  <= '0;
        text_len  <= '0;
        zero_seen <= 1'b0;
        found     <= 1'b0;
        remain    <= text_len;
      end else begin
        if (store) begin
          line_len <= line_len + 1'b1;
          if (in_item.in_byte == ZERO_BYTE) begin
            zero_seen <= 1'b1;
          end
        end
        if (search) begin
          text_len <= text_len + 1'b1;
          if (found_hit) begin
            found <= 1'b1;
          end
        end
        if (emit_byte) begin
          remain <= remain - 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_byte || emit_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_byte) begin
      out_item.out_byte     <= cell_data[0];
      out_item.last_of_line <= 1'b0;
    end else if (emit_last) begin
      out_item.out_byte     <= NEWLINE;
      out_item.last_of_line <= 1'b1;
    end
  end

  // Row of line byte cells
  for (genvar i = 0; i < LINE_MAX; i++) begin : g_byte
    logic [7:0] from_next;

    if (i == LINE_MAX - 1) begin : g_end
      assign from_next = ZERO_BYTE;
    end else begin : g_mid
      assign from_next = cell_data[i+1];
    end

    assign byte_ctrl[i].write = store && (line_len == LEN_W'(i));
    assign byte_ctrl[i].shift = emit_byte;

    lsf_byte_cell u_cell (
      .clk       (clk),
      .ctrl      (byte_ctrl[i]),
      .wdata     (in_item.in_byte),
      .from_next (from_next),
      .data      (cell_data[i])
    );
  end

  // Row of match cells
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_match
    logic prev_matched;

    if (k == 0) begin : g_first
      assign prev_matched = 1'b1;
    end else begin : g_rest
      assign prev_matched = matched[k-1];
    end

    lsf_match_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (match_ctrl),
      .line_byte    (in_item.in_byte),
      .pat_byte     (pattern_all[8*k +: 8]),
      .prev_matched (prev_matched),
      .hit          (hit[k]),
      .matched      (matched[k])
    );
  end

endmodule

// ===== hdl/lsf_checker.sv =====
// lsf_checker: port-level checks for line_substring_filter_unit, and its bind.
// Depends on lsf_pkg; sees the top level's ports only.
module lsf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_we,
  input logic [lsf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [lsf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input logic                            in_valid,
  input logic                            in_ready,
  input lsf_pkg::in_item_t               in_item,
  input logic                            out_valid,
  input logic                            out_ready,
  input lsf_pkg::out_item_t              out_item
);
  import lsf_pkg::*;

  // A stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // The item that ends a line is always the newline
  a_last_newline: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.last_of_line |-> out_item.out_byte == NEWLINE)
    else $error("last item of a line is not a newline");

  // Line bytes stop before a zero byte, so none is ever emitted
  a_no_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last_of_line |-> out_item.out_byte != ZERO_BYTE)
    else $error("zero byte emitted");

  // Input is held off while a line is still being emitted
  a_no_input_mid_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last_of_line |-> !in_ready)
    else $error("input taken in the middle of an emitted line");

endmodule

bind line_substring_filter_unit lsf_checker u_lsf_checker (.*);
